// ===== hdl/ppt_pkg.sv =====
package ppt_pkg;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 10;
  localparam int LABEL_W = 10;
  localparam int COL_W   = 8;
  localparam int PIX_W   = 8;

  localparam logic [CMD_W-1:0] CMD_NODE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WALK  = 2'd2;

  localparam logic [1:0] OP_NODE  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_WALK  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [COL_W-1:0]   col_a;
    logic [COL_W-1:0]   col_b;
    logic [SLOT_W-1:0]  kid_t;
    logic               has_t;
    logic [SLOT_W-1:0]  kid_f;
    logic               has_f;
  } node_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    node_t             node;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  pix;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_item_t;

endpackage

// ===== hdl/ppt_if.sv =====
interface ppt_in_if import ppt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [SLOT_W-1:0]  node_index;
  logic [LABEL_W-1:0] node_label;
  logic [COL_W-1:0]   first_column;
  logic [COL_W-1:0]   second_column;
  logic [SLOT_W-1:0]  true_child;
  logic               true_present;
  logic [SLOT_W-1:0]  false_child;
  logic               false_present;
  logic [COL_W-1:0]   column_index;
  logic [PIX_W-1:0]   pixel_value;

  modport source (
    output valid, command, node_index, node_label, first_column, second_column,
    output true_child, true_present, false_child, false_present,
    output column_index, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, command, node_index, node_label, first_column, second_column,
    input  true_child, true_present, false_child, false_present,
    input  column_index, pixel_value,
    output ready
  );
endinterface

interface ppt_out_if import ppt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] visited_label;
  logic               last;
  logic               tree_empty;
  logic               depth_cut;

  modport source (
    output valid, visited_label, last, tree_empty, depth_cut,
    input  ready
  );
  modport sink (
    input  valid, visited_label, last, tree_empty, depth_cut,
    output ready
  );
endinterface

// ===== hdl/ppt_front.sv =====
module ppt_front import ppt_pkg::*; #(
  parameter int NODE_COUNT      = 1024,
  parameter int FEATURE_COLUMNS = 256
) (
  input  logic    clk,
  input  logic    rst,
  ppt_in_if.sink  cmd,
  output q_item_t push,
  input  logic    push_ready
);

  logic   stage_valid;
  entry_t stage_entry;
  entry_t entry_next;
  logic   keep;

  always_comb begin
    entry_next            = '0;
    entry_next.slot       = cmd.node_index;
    entry_next.node.label = cmd.node_label;
    entry_next.node.col_a = cmd.first_column;
    entry_next.node.col_b = cmd.second_column;
    entry_next.node.kid_t = cmd.true_child;
    entry_next.node.has_t = cmd.true_present && (32'(cmd.true_child) < NODE_COUNT);
    entry_next.node.kid_f = cmd.false_child;
    entry_next.node.has_f = cmd.false_present && (32'(cmd.false_child) < NODE_COUNT);
    entry_next.col        = cmd.column_index;
    entry_next.pix        = cmd.pixel_value;
    case (cmd.command)
      CMD_NODE: begin
        entry_next.op = OP_NODE;
        keep          = 32'(cmd.node_index) < NODE_COUNT;
      end
      CMD_PIXEL: begin
        entry_next.op = OP_PIXEL;
        keep          = 32'(cmd.column_index) < FEATURE_COLUMNS;
      end
      CMD_WALK: begin
        entry_next.op = OP_WALK;
        keep          = 1'b1;
      end
      default: begin
        entry_next.op = OP_WALK;
        keep          = 1'b0;
      end
    endcase
  end

  assign cmd.ready  = !stage_valid || push_ready;
  assign push.valid = stage_valid;
  assign push.entry = stage_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      stage_valid <= keep;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stage_entry <= entry_next;
    end
  end

endmodule

// ===== hdl/ppt_queue.sv =====
module ppt_queue import ppt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_item_t push,
  output logic    push_ready,
  output q_item_t pop,
  input  logic    pop_ready
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop.valid  = count != '0;
  assign pop.entry  = slots[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count past depth");

endmodule

// ===== hdl/ppt_back.sv =====
module ppt_back import ppt_pkg::*; #(
  parameter int NODE_COUNT      = 1024,
  parameter int FEATURE_COLUMNS = 256,
  parameter int MAX_DEPTH       = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  q_item_t  pop,
  output logic     pop_ready,
  ppt_out_if.source res
);

  localparam int NODE_AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FEAT_AW  = (FEATURE_COLUMNS > 1) ? $clog2(FEATURE_COLUMNS) : 1;
  localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NODE = 2'd1;
  localparam logic [1:0] S_FEAT = 2'd2;

  node_t              node_mem [NODE_COUNT];
  logic [PIX_W-1:0]   feat_mem [FEATURE_COLUMNS];

  logic [1:0]         state;
  logic               root_present;
  logic [DEPTH_W-1:0] depth;
  node_t              node_q;
  logic [PIX_W-1:0]   pa_raw;
  logic [PIX_W-1:0]   pb_raw;

  logic               res_valid;
  logic [LABEL_W-1:0] res_label;
  logic               res_last;
  logic               res_empty;
  logic               res_cut;

  logic               out_free;
  logic               take;
  logic               res_load;
  logic [PIX_W-1:0]   pa;
  logic [PIX_W-1:0]   pb;
  logic               go_t;
  logic               has;
  logic [SLOT_W-1:0]  next;
  logic               at_cap;
  logic               node_rd;
  logic [NODE_AW-1:0] node_rd_addr;

  assign out_free  = !res_valid || res.ready;
  assign pop_ready = (state == S_IDLE)
                     && (pop.entry.op != OP_WALK || root_present || out_free);
  assign take      = pop.valid && pop_ready;
  assign res_load  = (take && pop.entry.op == OP_WALK && !root_present)
                     || (state == S_FEAT && out_free);

  assign pa     = (32'(node_q.col_a) < FEATURE_COLUMNS) ? pa_raw : '0;
  assign pb     = (32'(node_q.col_b) < FEATURE_COLUMNS) ? pb_raw : '0;
  assign go_t   = pa <= pb;
  assign has    = go_t ? node_q.has_t : node_q.has_f;
  assign next   = go_t ? node_q.kid_t : node_q.kid_f;
  assign at_cap = depth == DEPTH_W'(MAX_DEPTH);

  assign node_rd = (take && pop.entry.op == OP_WALK && root_present)
                   || (state == S_FEAT && out_free && has && !at_cap);
  assign node_rd_addr = (state == S_IDLE) ? '0 : NODE_AW'(next);

  always_ff @(posedge clk) begin
    if (take && pop.entry.op == OP_NODE) begin
      node_mem[NODE_AW'(pop.entry.slot)] <= pop.entry.node;
    end
    if (node_rd) begin
      node_q <= node_mem[node_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (take && pop.entry.op == OP_PIXEL) begin
      feat_mem[FEAT_AW'(pop.entry.col)] <= pop.entry.pix;
    end
    if (state == S_NODE) begin
      pa_raw <= feat_mem[FEAT_AW'(node_q.col_a)];
      pb_raw <= feat_mem[FEAT_AW'(node_q.col_b)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root_present <= 1'b0;
      depth        <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            case (pop.entry.op)
              OP_NODE: begin
                if (pop.entry.slot == '0) begin
                  root_present <= 1'b1;
                end
              end
              OP_WALK: begin
                if (root_present) begin
                  depth <= DEPTH_W'(1);
                  state <= S_NODE;
                end else begin
                  res_label <= '0;
                  res_last  <= 1'b1;
                  res_empty <= 1'b1;
                  res_cut   <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_NODE: begin
          state <= S_FEAT;
        end
        S_FEAT: begin
          if (out_free) begin
            res_label <= node_q.label;
            res_empty <= 1'b0;
            if (!has) begin
              res_last <= 1'b1;
              res_cut  <= 1'b0;
              state    <= S_IDLE;
            end else if (at_cap) begin
              res_last <= 1'b1;
              res_cut  <= 1'b1;
              state    <= S_IDLE;
            end else begin
              res_last <= 1'b0;
              res_cut  <= 1'b0;
              depth    <= depth + DEPTH_W'(1);
              state    <= S_NODE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid         = res_valid;
  assign res.visited_label = res_label;
  assign res.last          = res_last;
  assign res.tree_empty    = res_empty;
  assign res.depth_cut     = res_cut;

  a_cut_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_cut |-> res_last)
    else $error("depth cut on a non-final item");

  a_empty_alone: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_empty |-> res_last && !res_cut && res_label == '0)
    else $error("malformed empty-tree item");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_DEPTH))
    else $error("walk depth past cap");

  a_walk_needs_root: assert property (@(posedge clk) disable iff (rst)
    state == S_NODE |-> root_present && depth != '0)
    else $error("walk running without root");

endmodule

// ===== hdl/pixel_pair_tree_walk.sv =====
// Decision tree walker with pixel-pair tests. Commands come in on cmd: node
// write, pixel write, or walk (command 3 and writes past the table or feature
// row are dropped). A front stage accepts one item per cycle, while the queue
// has room, into a 4-entry queue; the back end executes them in order. For
// each visited node a walk does a registered node-table read, then the
// registered two-port feature read and compare; it visits at most MAX_DEPTH
// nodes and emits one result per node on res, the final one marked last. A
// walk with no root loaded gives a single result flagged tree_empty. Results
// wait in an output register; the back end stalls only while it holds an
// untaken result. Reading table slots or feature columns never written gives
// undefined labels and paths.
module pixel_pair_tree_walk import ppt_pkg::*; #(
  parameter int NODE_COUNT      = 1024,
  parameter int FEATURE_COLUMNS = 256,
  parameter int MAX_DEPTH       = 16
) (
  input  logic      clk,
  input  logic      rst,
  ppt_in_if.sink    cmd,
  ppt_out_if.source res
);

  q_item_t push;
  logic    push_ready;
  q_item_t pop;
  logic    pop_ready;

  ppt_front #(
    .NODE_COUNT      (NODE_COUNT),
    .FEATURE_COLUMNS (FEATURE_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push       (push),
    .push_ready (push_ready)
  );

  ppt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  ppt_back #(
    .NODE_COUNT      (NODE_COUNT),
    .FEATURE_COLUMNS (FEATURE_COLUMNS),
    .MAX_DEPTH       (MAX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_ready (pop_ready),
    .res       (res)
  );

endmodule
